/* hw/rtl/bwga_pkg.sv */
// Shared types and constants for the banded weighted Gram accumulator.
`timescale 1ns / 1ps
`default_nettype none
package bwga_pkg;
  localparam int KindW = 2;
  localparam logic [KindW-1:0] KIND_ACC   = 2'd0;
  localparam logic [KindW-1:0] KIND_READ  = 2'd1;
  localparam logic [KindW-1:0] KIND_CLEAR = 2'd2;
  localparam int EntryW = 48;
  localparam int NumFields = 4;
  localparam logic [EntryW-1:0] SAT48 = {EntryW{1'b1}};
  typedef logic [EntryW-1:0] entry_t;
endpackage
`default_nettype wire

/* hw/rtl/bwga_mac.sv */
// Shared two-stage multiply unit: basis product, then product times weight.
`timescale 1ns / 1ps
`default_nettype none
module bwga_mac (
  input  wire logic                 clk,
  input  wire logic [15:0]          ba,
  input  wire logic [15:0]          bc,
  input  wire logic [31:0]          w,
  output bwga_pkg::entry_t          term
);
  import bwga_pkg::*;
  logic [31:0] pp_r;
  logic [31:0] w_r;
  logic [63:0] full_r;
  // First stage: basis pair product; second stage: scale by weight.
  always_ff @(posedge clk) begin
    pp_r   <= 32'(ba) * 32'(bc);
    w_r    <= w;
    full_r <= 64'(pp_r) * 64'(w_r);
  end
  // Q18.46 to Q32.16; at most 34 bits survive, so no overflow into 48.
  assign term = EntryW'(full_r >> 30);
endmodule
`default_nettype wire

/* hw/rtl/banded_weighted_gram_accumulator_top.sv */
// Top level of the banded weighted Gram accumulator.
`timescale 1ns / 1ps
`default_nettype none
// Accumulates the band of X^T diag(w) X. An accumulate item walks its
// BAND*(BAND+1)/2 basis pairs through one shared multiplier pipeline
// (two multiply stages) and a read-modify-write on the band memory: each
// pair steps through read, multiply, multiply and write. A read item issues
// BAND memory reads, then a drain step, before its result is registered. A
// clear item, and the pass after reset, sweep every memory word, one a cycle:
// (MAX_BLOCKS+BAND-1)*BAND words, 1036 at the defaults, during which no
// item is accepted. The result sits in an output register; in_stall is high
// whenever the block is busy or a result is still waiting. Write cfg_ only
// while idle.
module banded_weighted_gram_accumulator_top #(
  parameter int BAND = 4,
  parameter int MAX_BLOCKS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [7:0]  in_block,
  input  wire logic [31:0] in_weight,
  input  wire logic [15:0] in_basis_0,
  input  wire logic [15:0] in_basis_1,
  input  wire logic [15:0] in_basis_2,
  input  wire logic [15:0] in_basis_3,
  input  wire logic [8:0]  in_read_row,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [8:0]       out_row_index,
  output logic [47:0]      out_band_0,
  output logic [47:0]      out_band_1,
  output logic [47:0]      out_band_2,
  output logic [47:0]      out_band_3
);
  import bwga_pkg::*;
  localparam int Rows  = MAX_BLOCKS + BAND - 1;
  localparam int Depth = Rows * BAND;
  localparam int AW    = $clog2(Depth);
  localparam int OW    = $clog2(BAND) > 0 ? $clog2(BAND) : 1;
  localparam int OCW   = $clog2(BAND + 1);

  localparam logic [2:0] S_IDLE = 3'd0, S_CLR = 3'd1, S_RD = 3'd2,
                         S_M1 = 3'd3, S_M2 = 3'd4, S_WR = 3'd5,
                         S_RDROW = 3'd6, S_DRAIN = 3'd7;

  logic [2:0]      state_r, state_nxt;
  logic [7:0]      limit_r;
  logic [AW-1:0]   clr_r;
  logic [OW-1:0]   a_r, c_r;        // pair indices
  logic [OCW-1:0]  rd_cnt_r;        // read offsets issued
  logic            rd_last_r;
  logic            rd_pend_r;       // memory read of previous cycle lands now
  logic [OW-1:0]   rd_off_r;
  logic [7:0]      blk_r;
  logic [31:0]     w_r;
  logic [15:0]     basis_r [BAND];
  logic [8:0]      row_r;
  logic            row_ok_r;
  entry_t          mem [Depth];
  entry_t          rdata_r;
  entry_t          band_r [NumFields];
  logic            out_valid_r;
  logic [AW-1:0]   addr;
  entry_t          term, sum;
  logic [48:0]     wide;
  logic [15:0]     basis_r_in [BAND];

  // Basis values beyond the four fields read as zero.
  always_comb begin
    for (int i = 0; i < BAND; i++) basis_r_in[i] = 16'd0;
    basis_r_in[0] = in_basis_0;
    basis_r_in[1] = in_basis_1;
    if (BAND > 2) basis_r_in[OW'(2 % BAND)] = in_basis_2;
    if (BAND > 3) basis_r_in[OW'(3 % BAND)] = in_basis_3;
  end

  bwga_mac u_mac (
    .clk (clk), .ba (basis_r[a_r]), .bc (basis_r[c_r]), .w (w_r), .term (term)
  );

  // Entry address of pair (a,c): row blk+a, offset c-a.
  always_comb begin
    addr = AW'((32'(blk_r) + 32'(a_r)) * BAND + (32'(c_r) - 32'(a_r)));
    if (state_r == S_RDROW) addr = AW'(32'(row_r) * BAND + 32'(rd_cnt_r));
  end

  assign wide = {1'b0, rdata_r} + {1'b0, term};
  assign sum  = wide[48] ? SAT48 : wide[47:0];

  // Band memory: one read and one write port, read data registered.
  always_ff @(posedge clk) begin
    if (state_r == S_CLR) mem[clr_r] <= '0;
    else if (state_r == S_WR) mem[addr] <= sum;
    rdata_r <= mem[addr];
  end

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) begin
        priority if (in_kind == KIND_CLEAR) state_nxt = S_CLR;
        else if (in_kind == KIND_READ) state_nxt = S_RDROW;
        else if (in_kind == KIND_ACC && in_block <= limit_r &&
                 32'(in_block) < MAX_BLOCKS) state_nxt = S_RD;
        else state_nxt = S_IDLE;
      end
      S_CLR:   if (32'(clr_r) == Depth - 1) state_nxt = S_IDLE;
      S_RD:    state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_WR;
      S_WR:    state_nxt = (32'(a_r) == BAND - 1) ? S_IDLE : S_RD;
      S_RDROW: if (32'(rd_cnt_r) == BAND - 1) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      limit_r     <= 8'd255;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
      if (state_r == S_CLR) clr_r <= (32'(clr_r) == Depth - 1) ? '0 : clr_r + 1'b1;
      rd_pend_r <= (state_r == S_RDROW);
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      else if (rd_pend_r && rd_last_r) out_valid_r <= 1'b1;
    end
  end

  // Payload and walk counters.
  always_ff @(posedge clk) begin
    rd_last_r <= (state_r == S_RDROW) && (32'(rd_cnt_r) == BAND - 1);
    rd_off_r  <= rd_cnt_r[OW-1:0];
    if (state_r == S_IDLE && accept) begin
      blk_r    <= in_block;
      w_r      <= in_weight;
      basis_r  <= basis_r_in;
      row_r    <= in_read_row;
      row_ok_r <= 32'(in_read_row) < Rows;
      a_r      <= '0;
      c_r      <= '0;
      rd_cnt_r <= '0;
      for (int i = 0; i < NumFields; i++) band_r[i] <= '0;
    end
    if (state_r == S_WR) begin
      // Advance to next pair a<=c.
      if (32'(c_r) == BAND - 1) begin
        a_r <= a_r + 1'b1;
        c_r <= a_r + 1'b1;
      end else c_r <= c_r + 1'b1;
    end
    if (state_r == S_RDROW) rd_cnt_r <= rd_cnt_r + 1'b1;
    if (rd_pend_r && row_ok_r && 32'(rd_off_r) < NumFields)
      band_r[rd_off_r] <= rdata_r;
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = row_r;
  assign out_band_0    = band_r[0];
  assign out_band_1    = band_r[1];
  assign out_band_2    = band_r[2];
  assign out_band_3    = band_r[3];

  // No item taken while a clear sweep runs.
  a_no_take_clr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> in_stall) else $error("accept during clear");
  // A result appears only after a row read.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_DRAIN) else $error("stray result");
  // Write state follows the multiply states M1 and M2.
  a_wr_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WR |-> $past(state_r, 2) == S_M1) else $error("mac timing");
endmodule
`default_nettype wire

/* test/tb_banded_weighted_gram_accumulator_top.sv */
// Testbench for the banded weighted Gram accumulator: directed and random checks.
`timescale 1ns / 1ps
module tb_banded_weighted_gram_accumulator_top;
  import bwga_pkg::*;

  localparam int BAND = 4;
  localparam int MAX_BLOCKS = 256;
  localparam int ROWS = MAX_BLOCKS + BAND - 1;
  localparam longint CYCLE_LIMIT = 2000000;
  // clear sweep plus margin; also covers the slowest accumulate item
  localparam int SETTLE = 1200;
  // kind code the block ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [8:0] row;
    entry_t     b0;
    entry_t     b1;
    entry_t     b2;
    entry_t     b3;
  } band_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = KIND_ACC;
  logic [7:0] in_block = '0;
  logic [31:0] in_weight = '0;
  logic [15:0] in_basis_0 = '0, in_basis_1 = '0, in_basis_2 = '0, in_basis_3 = '0;
  logic [8:0] in_read_row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [8:0] out_row_index;
  logic [47:0] out_band_0, out_band_1, out_band_2, out_band_3;

  banded_weighted_gram_accumulator_top #(.BAND(BAND), .MAX_BLOCKS(MAX_BLOCKS)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_block(in_block), .in_weight(in_weight),
    .in_basis_0(in_basis_0), .in_basis_1(in_basis_1),
    .in_basis_2(in_basis_2), .in_basis_3(in_basis_3),
    .in_read_row(in_read_row), .out_valid(out_valid), .out_stall(out_stall),
    .out_row_index(out_row_index), .out_band_0(out_band_0),
    .out_band_1(out_band_1), .out_band_2(out_band_2), .out_band_3(out_band_3)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the band memory and the block limit register.
  entry_t gram_band [ROWS][BAND];
  logic [7:0] limit_shadow;
  band_row_t pending_rows[$];
  int errors = 0;
  longint cycles = 0;
  // sender burst shaping and receiver hold-off
  bit gaps_on = 1'b1;
  int hold_req = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic entry_t sat_sum(entry_t acc, logic [63:0] add);
    logic [64:0] s;
    s = {17'b0, acc} + {1'b0, add};
    return (s > {17'b0, SAT48}) ? SAT48 : s[47:0];
  endfunction

  function automatic void clear_band();
    foreach (gram_band[r, o]) gram_band[r][o] = '0;
  endfunction

  // Fold one observation into the shadow store, as the block should.
  function automatic void fold_observation(logic [7:0] blk, logic [31:0] w,
                                           logic [15:0] b [BAND]);
    logic [63:0] term;
    if (blk > limit_shadow) return;
    for (int a = 0; a < BAND; a++)
      for (int c = a; c < BAND; c++) begin
        term = 64'(b[a]) * 64'(b[c]);
        term = (term * 64'(w)) >> 30;
        gram_band[blk + a][c - a] = sat_sum(gram_band[blk + a][c - a], term);
      end
  endfunction

  // Advance the shadow for one accepted transfer.
  function automatic void predict_transfer();
    logic [15:0] b [BAND];
    band_row_t r;
    b = '{in_basis_0, in_basis_1, in_basis_2, in_basis_3};
    if (in_kind == KIND_ACC) fold_observation(in_block, in_weight, b);
    else if (in_kind == KIND_CLEAR) clear_band();
    else if (in_kind == KIND_READ) begin
      r = '0;
      r.row = in_read_row;
      if (in_read_row < ROWS) begin
        r.b0 = gram_band[in_read_row][0];
        r.b1 = gram_band[in_read_row][1];
        r.b2 = gram_band[in_read_row][2];
        r.b3 = gram_band[in_read_row][3];
      end
      pending_rows.push_back(r);
    end
  endfunction

  always @(posedge clk) if (rst_n && in_valid && !in_stall) predict_transfer();

  // Check each result transfer against the oldest pending row.
  always @(posedge clk) begin
    band_row_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        errors++;
        $display("%0t: unexpected result row %0d", $time, out_row_index);
      end else begin
        e = pending_rows.pop_front();
        if (out_row_index !== e.row) begin
          errors++;
          $display("%0t: row_index exp %0d got %0d", $time, e.row, out_row_index);
        end
        if (out_band_0 !== e.b0) begin
          errors++;
          $display("%0t: band_0 exp %h got %h", $time, e.b0, out_band_0);
        end
        if (out_band_1 !== e.b1) begin
          errors++;
          $display("%0t: band_1 exp %h got %h", $time, e.b1, out_band_1);
        end
        if (out_band_2 !== e.b2) begin
          errors++;
          $display("%0t: band_2 exp %h got %h", $time, e.b2, out_band_2);
        end
        if (out_band_3 !== e.b3) begin
          errors++;
          $display("%0t: band_3 exp %h got %h", $time, e.b3, out_band_3);
        end
      end
    end
  end

  // Receiver: random stall pattern, with phases of none, plus long hold-offs on request.
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 60)) begin
        @(negedge clk);
        if (hold_req > 0) begin
          out_stall <= 1'b1;
          hold_req--;
        end else if (mode == 0) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 3) < mode);
      end
    end
  end

  // Offer one item and hold it until it transfers; gaps come between bursts.
  int burst_left = 0;
  task automatic send_item(logic [1:0] k, logic [7:0] blk, logic [31:0] w,
                           logic [15:0] b0, logic [15:0] b1, logic [15:0] b2,
                           logic [15:0] b3, logic [8:0] row);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_block <= blk;
    in_weight <= w;
    in_basis_0 <= b0;
    in_basis_1 <= b1;
    in_basis_2 <= b2;
    in_basis_3 <= b3;
    in_read_row <= row;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  // Drop valid and wait for the block to drain, then let the latency pass.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_limit(logic [7:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    limit_shadow = v;
  endtask

  task automatic read_row(logic [8:0] r);
    send_item(KIND_READ, 8'($urandom), 32'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), r);
  endtask

  function automatic logic [15:0] rand_basis();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // Extremes of the fields, largest terms, edge rows, unused kind and clear.
  task automatic test_directed();
    send_item(KIND_ACC, 8'd0, 32'h0001_0000, 16'd32768, 16'd16384, 16'd0, 16'd1, 9'd0);
    send_item(KIND_ACC, 8'd255, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              9'd0);
    repeat (3)
      send_item(KIND_ACC, 8'd255, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 9'd0);
    read_row(9'd0);
    read_row(9'd1);
    read_row(9'd255);
    read_row(9'd258);
    read_row(9'd259);
    read_row(9'h1FF);
    read_row(9'd100);
    send_item(KIND_UNUSED, 8'd1, 32'h1234_5678, 16'd5, 16'd5, 16'd5, 16'd5, 9'd1);
    read_row(9'd1);
    send_item(KIND_CLEAR, 8'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 9'd0);
    read_row(9'd0);
    read_row(9'd258);
  endtask

  // Limit the contributing blocks and check that later ones are ignored.
  task automatic test_block_limit(logic [7:0] lim);
    write_limit(lim);
    send_item(KIND_ACC, lim, 32'h0002_0000, 16'd32768, 16'd32768, 16'd1000, 16'd7, 9'd0);
    if (lim != 8'd255)
      send_item(KIND_ACC, lim + 8'd1, 32'h0002_0000, 16'd32768, 16'd32768, 16'd9, 16'd9,
                9'd0);
    for (int i = 0; i < 5; i++) read_row(9'(lim) + 9'(i));
  endtask

  // Random mix: mostly observations on a few nearby blocks, read-back and rare clears.
  task automatic test_random(int n);
    logic [7:0] base;
    logic [1:0] k;
    int pick;
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) k = KIND_ACC;
      else if (pick < 97) k = KIND_READ;
      else if (pick == 97) k = KIND_CLEAR;
      else k = KIND_UNUSED;
      if ($urandom_range(0, 49) == 0) base = $urandom;
      send_item(k, ($urandom_range(0, 3) == 0) ? 8'($urandom) : base + 8'($urandom_range(0, 6)),
                ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 32'h0004_0000)),
                rand_basis(), rand_basis(), rand_basis(), rand_basis(),
                ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'(base) + 9'($urandom_range(0, 9)));
    end
  endtask

  // Hold the receiver off for a long stretch while items keep coming.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_req = 400;
    for (int i = 0; i < 30; i++) read_row(9'($urandom_range(0, 300)));
    gaps_on = 1'b1;
  endtask

  initial begin
    clear_band();
    limit_shadow = 8'd255;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE) @(negedge clk);
    test_directed();
    test_block_limit(8'd0);
    test_block_limit(8'd100);
    test_block_limit(8'd254);
    test_block_limit(8'd255);
    test_backpressure();
    write_limit(8'd200);
    test_random(500);
    write_limit(8'd255);
    test_random(900);
    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
